// ----- design/c65alu_pkg.sv -----
`default_nettype none

package c65alu_pkg;

   // Operation numbers carried in the mode field of a request.
   typedef enum logic [5:0] {
      OP_ADC = 6'd0,
      OP_SBC = 6'd1,
      OP_AND = 6'd2,
      OP_ORA = 6'd3,
      OP_EOR = 6'd4,
      OP_ASL = 6'd5,
      OP_LSR = 6'd6,
      OP_ROL = 6'd7,
      OP_ROR = 6'd8,
      OP_INC = 6'd9,
      OP_DEC = 6'd10,
      OP_CMP = 6'd11,
      OP_CPX = 6'd12,
      OP_CPY = 6'd13,
      OP_BIT = 6'd14,
      OP_LDA = 6'd15,
      OP_LDX = 6'd16,
      OP_LDY = 6'd17,
      OP_STA = 6'd18,
      OP_STX = 6'd19,
      OP_STY = 6'd20,
      OP_INX = 6'd21,
      OP_INY = 6'd22,
      OP_DEX = 6'd23,
      OP_DEY = 6'd24,
      OP_TAX = 6'd25,
      OP_TAY = 6'd26,
      OP_TXA = 6'd27,
      OP_TYA = 6'd28,
      OP_CLC = 6'd29,
      OP_SEC = 6'd30,
      OP_CLI = 6'd31,
      OP_SEI = 6'd32,
      OP_CLD = 6'd33,
      OP_SED = 6'd34,
      OP_CLV = 6'd35,
      OP_PHP = 6'd36,
      OP_PLP = 6'd37,
      OP_PLA = 6'd38
   } op_type;

   // Status byte bit positions.
   localparam int unsigned STATUS_UNUSED_BIT = 5;
   localparam int unsigned STATUS_BREAK_BIT  = 4;

   // Request transaction payload.
   typedef struct packed {
      logic [5:0] mode;
      logic [7:0] operand;
      logic       on_accumulator;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [7:0] result_byte;
      logic [7:0] acc;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] status;
   } rsp_type;

   // Architectural registers and flags.
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic       n;
      logic       v;
      logic       d;
      logic       i;
      logic       z;
      logic       c;
   } arch_type;

   // Packs the flags as N V 1 B D I Z C with B clear.
   function automatic logic [7:0] pack_status(input arch_type st);
      logic [7:0] p;
      p = {st.n, st.v, 1'b0, 1'b0, st.d, st.i, st.z, st.c};
      p[STATUS_UNUSED_BIT] = 1'b1;
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- design/c65alu_exec.sv -----
`default_nettype none

module c65alu_exec (
   input  c65alu_pkg::req_type  op_in,
   input  c65alu_pkg::arch_type state_in,
   output c65alu_pkg::arch_type state_out,
   output logic [7:0]           wb_out
);
   import c65alu_pkg::*;

   logic [7:0] shift_src;
   logic [7:0] shift_res;
   logic       shift_carry;
   logic [7:0] add_operand;
   logic [8:0] add_sum;
   logic       add_ovf;
   logic [7:0] cmp_reg;
   logic [8:0] cmp_diff;
   logic [7:0] mem_inc;
   logic [7:0] mem_dec;
   logic [7:0] push_byte;

   // Shift and rotate unit, fed from A or the operand.
   assign shift_src = op_in.on_accumulator ? state_in.acc : op_in.operand;

   always_comb begin
      shift_res   = shift_src;
      shift_carry = state_in.c;
      case (op_in.mode)
         OP_ASL: begin
            shift_res   = {shift_src[6:0], 1'b0};
            shift_carry = shift_src[7];
         end
         OP_LSR: begin
            shift_res   = {1'b0, shift_src[7:1]};
            shift_carry = shift_src[0];
         end
         OP_ROL: begin
            shift_res   = {shift_src[6:0], state_in.c};
            shift_carry = shift_src[7];
         end
         OP_ROR: begin
            shift_res   = {state_in.c, shift_src[7:1]};
            shift_carry = shift_src[0];
         end
         default: begin
            shift_res   = shift_src;
            shift_carry = state_in.c;
         end
      endcase
   end

   // Binary adder for ADC and SBC; SBC adds the inverted operand.
   assign add_operand = (op_in.mode == OP_SBC) ? ~op_in.operand : op_in.operand;
   assign add_sum     = {1'b0, state_in.acc} + {1'b0, add_operand} + {8'd0, state_in.c};
   assign add_ovf     = ~(state_in.acc[7] ^ add_operand[7]) & (state_in.acc[7] ^ add_sum[7]);

   // Compare subtractor; a borrow out means the register is below the operand.
   always_comb begin
      case (op_in.mode)
         OP_CPX:  cmp_reg = state_in.x;
         OP_CPY:  cmp_reg = state_in.y;
         default: cmp_reg = state_in.acc;
      endcase
   end

   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, op_in.operand};

   assign mem_inc   = op_in.operand + 8'd1;
   assign mem_dec   = op_in.operand - 8'd1;
   assign push_byte = pack_status(state_in) | (8'h01 << STATUS_BREAK_BIT);

   // Main operation select: next registers, flags and write-back byte.
   always_comb begin
      state_out = state_in;
      wb_out    = 8'h00;
      case (op_in.mode)
         OP_ADC, OP_SBC: begin
            state_out.acc = add_sum[7:0];
            state_out.c   = add_sum[8];
            state_out.v   = add_ovf;
            state_out.n   = add_sum[7];
            state_out.z   = (add_sum[7:0] == 8'h00);
         end
         OP_AND: begin
            state_out.acc = state_in.acc & op_in.operand;
            state_out.n   = state_out.acc[7];
            state_out.z   = (state_out.acc == 8'h00);
         end
         OP_ORA: begin
            state_out.acc = state_in.acc | op_in.operand;
            state_out.n   = state_out.acc[7];
            state_out.z   = (state_out.acc == 8'h00);
         end
         OP_EOR: begin
            state_out.acc = state_in.acc ^ op_in.operand;
            state_out.n   = state_out.acc[7];
            state_out.z   = (state_out.acc == 8'h00);
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            state_out.c = shift_carry;
            state_out.n = shift_res[7];
            state_out.z = (shift_res == 8'h00);
            if (op_in.on_accumulator) begin
               state_out.acc = shift_res;
            end else begin
               wb_out = shift_res;
            end
         end
         OP_INC: begin
            wb_out      = mem_inc;
            state_out.n = mem_inc[7];
            state_out.z = (mem_inc == 8'h00);
         end
         OP_DEC: begin
            wb_out      = mem_dec;
            state_out.n = mem_dec[7];
            state_out.z = (mem_dec == 8'h00);
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            state_out.c = ~cmp_diff[8];
            state_out.n = cmp_diff[7];
            state_out.z = (cmp_diff[7:0] == 8'h00);
         end
         OP_BIT: begin
            state_out.n = op_in.operand[7];
            state_out.v = op_in.operand[6];
            state_out.z = ((state_in.acc & op_in.operand) == 8'h00);
         end
         OP_LDA, OP_PLA: begin
            state_out.acc = op_in.operand;
            state_out.n   = op_in.operand[7];
            state_out.z   = (op_in.operand == 8'h00);
         end
         OP_LDX: begin
            state_out.x = op_in.operand;
            state_out.n = op_in.operand[7];
            state_out.z = (op_in.operand == 8'h00);
         end
         OP_LDY: begin
            state_out.y = op_in.operand;
            state_out.n = op_in.operand[7];
            state_out.z = (op_in.operand == 8'h00);
         end
         OP_STA: wb_out = state_in.acc;
         OP_STX: wb_out = state_in.x;
         OP_STY: wb_out = state_in.y;
         OP_INX: begin
            state_out.x = state_in.x + 8'd1;
            state_out.n = state_out.x[7];
            state_out.z = (state_out.x == 8'h00);
         end
         OP_INY: begin
            state_out.y = state_in.y + 8'd1;
            state_out.n = state_out.y[7];
            state_out.z = (state_out.y == 8'h00);
         end
         OP_DEX: begin
            state_out.x = state_in.x - 8'd1;
            state_out.n = state_out.x[7];
            state_out.z = (state_out.x == 8'h00);
         end
         OP_DEY: begin
            state_out.y = state_in.y - 8'd1;
            state_out.n = state_out.y[7];
            state_out.z = (state_out.y == 8'h00);
         end
         OP_TAX: begin
            state_out.x = state_in.acc;
            state_out.n = state_in.acc[7];
            state_out.z = (state_in.acc == 8'h00);
         end
         OP_TAY: begin
            state_out.y = state_in.acc;
            state_out.n = state_in.acc[7];
            state_out.z = (state_in.acc == 8'h00);
         end
         OP_TXA: begin
            state_out.acc = state_in.x;
            state_out.n   = state_in.x[7];
            state_out.z   = (state_in.x == 8'h00);
         end
         OP_TYA: begin
            state_out.acc = state_in.y;
            state_out.n   = state_in.y[7];
            state_out.z   = (state_in.y == 8'h00);
         end
         OP_CLC: state_out.c = 1'b0;
         OP_SEC: state_out.c = 1'b1;
         OP_CLI: state_out.i = 1'b0;
         OP_SEI: state_out.i = 1'b1;
         OP_CLD: state_out.d = 1'b0;
         OP_SED: state_out.d = 1'b1;
         OP_CLV: state_out.v = 1'b0;
         OP_PHP: wb_out = push_byte;
         OP_PLP: begin
            // Bits 5 and 4 of the pulled byte have no stored flag.
            state_out.n = op_in.operand[7];
            state_out.v = op_in.operand[6];
            state_out.d = op_in.operand[3];
            state_out.i = op_in.operand[2];
            state_out.z = op_in.operand[1];
            state_out.c = op_in.operand[0];
         end
         default: begin
            state_out = state_in;
            wb_out    = 8'h00;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/cpu_6502_alu_and_flags.sv -----
`default_nettype none

// 6502 data path and status flags, binary arithmetic only.
// The request channel (req_valid, req_ready, req_data) carries one data
// instruction per transaction: an operation number, an operand byte and a
// flag that points the shifts and rotates at A. The response channel
// (rsp_valid, rsp_ready, rsp_data) returns one transaction per request with
// the write-back byte, A, X, Y and the packed status N V 1 B D I Z C.
// A request is captured in an input register and executed, once the
// response register is free, against the register file, which is updated
// at the same edge that loads the response register and sets rsp_valid.
// While rsp_ready stays high the block takes one request per cycle; that
// rate rests on the loop from the register file through the execute logic
// and back.
// When the receiver holds rsp_ready low the response register keeps its
// transaction, the queued request waits in the input register, and
// req_ready drops until the response is taken.
// Reset clears A, X, Y, all flags and both valid bits.
module cpu_6502_alu_and_flags (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire c65alu_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output c65alu_pkg::rsp_type      rsp_data
);
   import c65alu_pkg::*;

   logic     req_valid_ff;
   req_type  req_ff;
   arch_type arch_ff;
   arch_type arch_in;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic [7:0] wb_byte;
   logic     exec_fire;

   // Execute when a request is queued and the response register is free.
   assign exec_fire = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || exec_fire;

   c65alu_exec u_exec (
      .op_in     (req_ff),
      .state_in  (arch_ff),
      .state_out (arch_in),
      .wb_out    (wb_byte)
   );

   always_comb begin
      rsp_in.result_byte = wb_byte;
      rsp_in.acc         = arch_in.acc;
      rsp_in.index_x     = arch_in.x;
      rsp_in.index_y     = arch_in.y;
      rsp_in.status      = pack_status(arch_in);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Register file and flags, updated as each transaction executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff <= '0;
      end else if (exec_fire) begin
         arch_ff <= arch_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

import c65alu_pkg::*;

// Tracks the architectural state of the data path and keeps the responses
// that the block still owes, oldest first.
class c65_state_checker;
   logic [7:0] reg_a;
   logic [7:0] reg_x;
   logic [7:0] reg_y;
   logic       flag_n;
   logic       flag_v;
   logic       flag_d;
   logic       flag_i;
   logic       flag_z;
   logic       flag_c;
   rsp_type    owed_responses[$];
   int         failures;
   int         reports;

   function new();
      reg_a = 8'h00;
      reg_x = 8'h00;
      reg_y = 8'h00;
      {flag_n, flag_v, flag_d, flag_i, flag_z, flag_c} = 6'b000000;
      failures = 0;
      reports = 0;
   endfunction

   function void set_nz(logic [7:0] value);
      flag_z = (value == 8'h00);
      flag_n = value[7];
   endfunction

   // The packed status always shows bit 5 set and the break bit clear.
   function logic [7:0] status_byte();
      return {flag_n, flag_v, 1'b1, 1'b0, flag_d, flag_i, flag_z, flag_c};
   endfunction

   function void compare_with(logic [7:0] register, logic [7:0] value);
      flag_c = (register >= value);
      set_nz(register - value);
   endfunction

   // Executes one instruction against the tracked state and returns the
   // response that the block must produce for it.
   function rsp_type execute_instruction(req_type item);
      logic [7:0] value;
      logic [7:0] addend;
      logic [8:0] sum;
      logic [7:0] shift_in;
      logic [7:0] shifted;
      rsp_type    resp;
      value = item.operand;
      resp.result_byte = 8'h00;
      case (item.mode)
         OP_ADC, OP_SBC: begin
            // Decimal mode never applies, so SBC is ADC of the inverted byte.
            addend = (item.mode == OP_SBC) ? ~value : value;
            sum = {1'b0, reg_a} + {1'b0, addend} + {8'h00, flag_c};
            flag_c = sum[8];
            flag_v = ~(reg_a[7] ^ addend[7]) & (reg_a[7] ^ sum[7]);
            reg_a = sum[7:0];
            set_nz(reg_a);
         end
         OP_AND: begin
            reg_a = reg_a & value;
            set_nz(reg_a);
         end
         OP_ORA: begin
            reg_a = reg_a | value;
            set_nz(reg_a);
         end
         OP_EOR: begin
            reg_a = reg_a ^ value;
            set_nz(reg_a);
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            shift_in = item.on_accumulator ? reg_a : value;
            case (item.mode)
               OP_ASL: shifted = {shift_in[6:0], 1'b0};
               OP_LSR: shifted = {1'b0, shift_in[7:1]};
               OP_ROL: shifted = {shift_in[6:0], flag_c};
               default: shifted = {flag_c, shift_in[7:1]};
            endcase
            flag_c = (item.mode == OP_ASL || item.mode == OP_ROL) ? shift_in[7] : shift_in[0];
            set_nz(shifted);
            if (item.on_accumulator) begin
               reg_a = shifted;
            end else begin
               resp.result_byte = shifted;
            end
         end
         OP_INC: begin
            resp.result_byte = value + 8'h01;
            set_nz(resp.result_byte);
         end
         OP_DEC: begin
            resp.result_byte = value - 8'h01;
            set_nz(resp.result_byte);
         end
         OP_CMP: compare_with(reg_a, value);
         OP_CPX: compare_with(reg_x, value);
         OP_CPY: compare_with(reg_y, value);
         OP_BIT: begin
            flag_n = value[7];
            flag_v = value[6];
            flag_z = ((reg_a & value) == 8'h00);
         end
         OP_LDA, OP_PLA: begin
            reg_a = value;
            set_nz(reg_a);
         end
         OP_LDX: begin
            reg_x = value;
            set_nz(reg_x);
         end
         OP_LDY: begin
            reg_y = value;
            set_nz(reg_y);
         end
         OP_STA: resp.result_byte = reg_a;
         OP_STX: resp.result_byte = reg_x;
         OP_STY: resp.result_byte = reg_y;
         OP_INX: begin
            reg_x = reg_x + 8'h01;
            set_nz(reg_x);
         end
         OP_INY: begin
            reg_y = reg_y + 8'h01;
            set_nz(reg_y);
         end
         OP_DEX: begin
            reg_x = reg_x - 8'h01;
            set_nz(reg_x);
         end
         OP_DEY: begin
            reg_y = reg_y - 8'h01;
            set_nz(reg_y);
         end
         OP_TAX: begin
            reg_x = reg_a;
            set_nz(reg_x);
         end
         OP_TAY: begin
            reg_y = reg_a;
            set_nz(reg_y);
         end
         OP_TXA: begin
            reg_a = reg_x;
            set_nz(reg_a);
         end
         OP_TYA: begin
            reg_a = reg_y;
            set_nz(reg_a);
         end
         OP_CLC: flag_c = 1'b0;
         OP_SEC: flag_c = 1'b1;
         OP_CLI: flag_i = 1'b0;
         OP_SEI: flag_i = 1'b1;
         OP_CLD: flag_d = 1'b0;
         OP_SED: flag_d = 1'b1;
         OP_CLV: flag_v = 1'b0;
         // The pushed copy carries both bit 5 and the break bit set.
         OP_PHP: resp.result_byte = status_byte() | 8'h30;
         // Bits 5 and 4 of the pulled byte are not stored.
         OP_PLP: begin
            flag_n = value[7];
            flag_v = value[6];
            flag_d = value[3];
            flag_i = value[2];
            flag_z = value[1];
            flag_c = value[0];
         end
         default: ;
      endcase
      resp.acc = reg_a;
      resp.index_x = reg_x;
      resp.index_y = reg_y;
      resp.status = status_byte();
      return resp;
   endfunction

   function void note_instruction(req_type item);
      owed_responses.push_back(execute_instruction(item));
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (owed_responses.size() == 0) begin
         failures++;
         if (reports < 10) begin
            reports++;
            $display("ERROR: response %h with no instruction outstanding", got);
         end
         return;
      end
      want = owed_responses.pop_front();
      if (got.result_byte !== want.result_byte || got.acc !== want.acc ||
          got.index_x !== want.index_x || got.index_y !== want.index_y ||
          got.status !== want.status) begin
         failures++;
         if (reports < 10) begin
            reports++;
            $display("ERROR: wb exp %h got %h, A exp %h got %h, X exp %h got %h, Y exp %h got %h, P exp %h got %h",
                     want.result_byte, got.result_byte, want.acc, got.acc,
                     want.index_x, got.index_x, want.index_y, got.index_y,
                     want.status, got.status);
         end
      end
   endfunction

   function int outstanding();
      return owed_responses.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int CALM_TAIL     = 200;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   c65_state_checker book = new();
   int               cycle_count = 0;
   bit               idle_enable = 1'b1;

   cpu_6502_alu_and_flags dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watch both channels at every edge; also bound the run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cpu_6502_alu_and_flags test failed");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         book.note_instruction(req_data);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_response(rsp_data);
      end
   end

   // The receiver stalls in bursts while idling is allowed.
   initial begin
      repeat (2) @(posedge clock);
      forever begin
         if (!idle_enable || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(logic [5:0] mode, logic [7:0] operand,
                                        logic on_accumulator);
      req_type item;
      item.mode = mode;
      item.operand = operand;
      item.on_accumulator = on_accumulator;
      return item;
   endfunction

   // Presents one transaction, holds it until accepted, then maybe idles.
   task automatic send_instruction(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   initial begin
      req_type directed[$];
      req_type item;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Flag corners, write-back rules, pulled status bits and unused modes.
      directed.push_back(make_req(OP_LDA, 8'h00, 1'b0));
      directed.push_back(make_req(OP_LDA, 8'h80, 1'b0));
      directed.push_back(make_req(OP_ADC, 8'h80, 1'b0));
      directed.push_back(make_req(OP_LDA, 8'h7F, 1'b0));
      directed.push_back(make_req(OP_ADC, 8'h01, 1'b0));
      directed.push_back(make_req(OP_SED, 8'h00, 1'b0));
      directed.push_back(make_req(OP_ADC, 8'h09, 1'b0));
      directed.push_back(make_req(OP_SBC, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_ASL, 8'h00, 1'b1));
      directed.push_back(make_req(OP_ASL, 8'h80, 1'b0));
      directed.push_back(make_req(OP_ROR, 8'h01, 1'b0));
      directed.push_back(make_req(OP_ROL, 8'hFF, 1'b1));
      directed.push_back(make_req(OP_LSR, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_INC, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_DEC, 8'h00, 1'b0));
      directed.push_back(make_req(OP_LDX, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_CPX, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_CPY, 8'h01, 1'b0));
      directed.push_back(make_req(OP_BIT, 8'hC0, 1'b0));
      directed.push_back(make_req(OP_PHP, 8'h00, 1'b0));
      directed.push_back(make_req(OP_PLP, 8'hFF, 1'b0));
      directed.push_back(make_req(OP_PHP, 8'h00, 1'b1));
      directed.push_back(make_req(OP_PLP, 8'h00, 1'b0));
      directed.push_back(make_req(OP_PLA, 8'h80, 1'b0));
      directed.push_back(make_req(OP_STA, 8'hFF, 1'b1));
      directed.push_back(make_req(6'h3F, 8'hFF, 1'b1));
      directed.push_back(make_req(OP_TAX, 8'h00, 1'b0));
      foreach (directed[k]) begin
         send_instruction(directed[k]);
      end

      // Every mode number once, unused ones included.
      for (int k = 0; k < 64; k++) begin
         send_instruction(make_req(6'(k), 8'($urandom), 1'($urandom)));
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k >= RANDOM_ITEMS - CALM_TAIL) begin
            idle_enable = 1'b0;
         end else if (k % 50 == 0) begin
            idle_enable = ($urandom_range(0, 3) != 0);
         end

         // Let the block drain completely once before going on.
         if (k == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (book.outstanding() != 0);
         end

         if ($urandom_range(0, 11) == 0) begin
            item.mode = 6'($urandom_range(39, 63));
         end else begin
            item.mode = 6'($urandom_range(0, 38));
         end
         case ($urandom_range(0, 7))
            0: item.operand = 8'h00;
            1: item.operand = 8'hFF;
            2: item.operand = 8'h80;
            3: item.operand = 8'h7F;
            // Equal to the tracked accumulator value, so equal compares turn up.
            4: item.operand = book.reg_a;
            default: item.operand = 8'($urandom);
         endcase
         item.on_accumulator = 1'($urandom);
         send_instruction(item);
      end

      // Wait for the last responses, then keep the clock running for strays.
      req_valid <= 1'b0;
      do @(posedge clock); while (book.outstanding() != 0);
      repeat (10) @(posedge clock);
      if (book.failures == 0 && book.outstanding() == 0) begin
         $display("cpu_6502_alu_and_flags test passed");
      end else begin
         $display("cpu_6502_alu_and_flags test failed");
      end
      $finish;
   end
endmodule
